@@ sv/lpg_pkg.sv @@
package lpg_pkg;

    // divider geometry
    localparam int NUM_W = 32;
    localparam int DEN_W = 22;

    // field widths
    localparam int LEVEL_W = 8;
    localparam int TIME_W  = 16;
    localparam int FADE_W  = 18;

    // mode codes
    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_SOLID = 3'd1;
    localparam logic [2:0] MODE_BLINK = 3'd2;
    localparam logic [2:0] MODE_FADE  = 3'd3;
    localparam logic [2:0] MODE_SOS   = 3'd4;
    localparam logic [2:0] MODE_SEQ   = 3'd5;

    // register indexes
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_BRIGHT   = 3'd1;
    localparam logic [2:0] REG_ON       = 3'd2;
    localparam logic [2:0] REG_OFF      = 3'd3;
    localparam logic [2:0] REG_FADE_IN  = 3'd4;
    localparam logic [2:0] REG_HOLD     = 3'd5;
    localparam logic [2:0] REG_FADE_OUT = 3'd6;
    localparam logic [2:0] REG_GAP      = 3'd7;

    // sos schedule: running end of each segment in units, and lit flags
    localparam int SOS_SEGMENTS = 18;
    localparam logic [5:0] SOS_TOTAL = 6'd34;
    localparam logic [5:0] SOS_END [SOS_SEGMENTS] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd8, 6'd11, 6'd12, 6'd15,
        6'd16, 6'd19, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd34
    };
    localparam logic [SOS_SEGMENTS-1:0] SOS_LIT = 18'b010101010101010101;

    // what the pipeline does with an item at the next decision point
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_BRIGHT,
        SEL_BLINK,
        SEL_FADE,
        SEL_SOS,
        SEL_SEQ,
        SEL_QUOT
    } t_sel;

    typedef struct packed {
        t_sel       sel;
        logic [3:0] k;
        logic [4:0] n;
    } t_ctx;

    typedef struct packed {
        logic [2:0]        mode;
        logic [7:0]        brightness;
        logic [TIME_W-1:0] on_ms;
        logic [TIME_W-1:0] off_ms;
        logic [TIME_W-1:0] fade_in_ms;
        logic [TIME_W-1:0] hold_ms;
        logic [TIME_W-1:0] fade_out_ms;
        logic [TIME_W-1:0] gap_ms;
    } t_cfg;

endpackage

@@ sv/lpg_div.sv @@
module lpg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lpg_pkg::NUM_W-1:0] i_num,
    input  logic [lpg_pkg::DEN_W-1:0] i_den,
    input  lpg_pkg::t_ctx             i_ctx,
    output logic                      o_valid,
    output logic [lpg_pkg::NUM_W-1:0] o_quot,
    output logic [lpg_pkg::DEN_W-1:0] o_rem,
    output lpg_pkg::t_ctx             o_ctx
);

    localparam int N = lpg_pkg::NUM_W;
    localparam int D = lpg_pkg::DEN_W;

    logic          r_vld [N];
    logic [N-1:0]  r_w   [N];
    logic [D-1:0]  r_rem [N];
    logic [D-1:0]  r_den [N];
    lpg_pkg::t_ctx r_ctx [N];

    // one restoring quotient bit per stage
    for (genvar g = 0; g < N; g++) begin : g_stage
        logic          p_vld;
        logic [N-1:0]  p_w;
        logic [D-1:0]  p_rem;
        logic [D-1:0]  p_den;
        lpg_pkg::t_ctx p_ctx;
        logic [D:0]    cand;
        logic [D+1:0]  diff;
        logic          ge;

        // stage input: the ports for the first stage, the previous stage otherwise
        if (g == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_w   = i_num;
            assign p_rem = '0;
            assign p_den = i_den;
            assign p_ctx = i_ctx;
        end else begin : g_next
            assign p_vld = r_vld[g-1];
            assign p_w   = r_w[g-1];
            assign p_rem = r_rem[g-1];
            assign p_den = r_den[g-1];
            assign p_ctx = r_ctx[g-1];
        end

        always_comb begin
            cand = {p_rem, p_w[N-1]};
            diff = {1'b0, cand} - {2'b00, p_den};
            ge   = ~diff[D+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
            r_w[g]   <= {p_w[N-2:0], ge};
            r_rem[g] <= ge ? diff[D-1:0] : cand[D-1:0];
            r_den[g] <= p_den;
            r_ctx[g] <= p_ctx;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quot  = r_w[N-1];
    assign o_rem   = r_rem[N-1];
    assign o_ctx   = r_ctx[N-1];

endmodule

@@ sv/lpg_phase.sv @@
module lpg_phase (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lpg_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    input  logic [lpg_pkg::DEN_W-1:0] i_pos,
    input  lpg_pkg::t_ctx             i_ctx,
    output logic                      o_valid,
    output logic [lpg_pkg::NUM_W-1:0] o_num,
    output logic [lpg_pkg::DEN_W-1:0] o_den,
    output lpg_pkg::t_ctx             o_ctx
);

    localparam int TW = lpg_pkg::TIME_W;
    localparam int FW = lpg_pkg::FADE_W;
    localparam int DW = lpg_pkg::DEN_W;

    logic          r_vld1;
    lpg_pkg::t_ctx r_ctx1;
    logic [TW-1:0] r_num1;
    logic [TW-1:0] r_den1;
    logic          r_vld2;
    lpg_pkg::t_ctx r_ctx2;
    logic [TW+7:0] r_prod2;
    logic [TW-1:0] r_den2;

    lpg_pkg::t_sel n_sel;
    logic [TW-1:0] n_num;
    logic [TW-1:0] n_den;
    logic [FW-1:0] s_in;
    logic [FW-1:0] s_hold;
    logic [FW-1:0] s_out;
    logic [FW-1:0] pos_f;
    logic [TW-1:0] unit;
    logic [DW-1:0] bound;
    logic          sos_lit;
    logic [20:0]   seq_start;
    logic [20:0]   seq_end;
    logic [20:0]   seq_period;
    logic          seq_lit;

    // fade segment ends
    assign s_in   = {2'b00, i_cfg.fade_in_ms};
    assign s_hold = s_in + {2'b00, i_cfg.hold_ms};
    assign s_out  = s_hold + {2'b00, i_cfg.fade_out_ms};
    assign pos_f  = i_pos[FW-1:0];

    // sos segment search, last match from the top wins
    always_comb begin
        unit    = (i_cfg.on_ms == '0) ? TW'(1) : i_cfg.on_ms;
        sos_lit = 1'b0;
        bound   = '0;
        for (int i = lpg_pkg::SOS_SEGMENTS - 1; i >= 0; i--) begin
            bound = DW'(lpg_pkg::SOS_END[i]) * DW'(unit);
            if (i_pos < bound) begin
                sos_lit = lpg_pkg::SOS_LIT[i];
            end
        end
    end

    // sequence window with wrap past the period end
    always_comb begin
        seq_start  = 21'(i_ctx.k) * 21'(i_cfg.on_ms);
        seq_end    = seq_start + 21'(i_cfg.on_ms) + 21'(i_cfg.off_ms);
        seq_period = 21'(i_ctx.n) * 21'(i_cfg.on_ms);
        seq_lit    = (i_pos >= 22'(seq_start)) && (i_pos < 22'(seq_end));
        if (!seq_lit && (seq_end > seq_period)) begin
            seq_lit = i_pos < 22'(seq_end - seq_period);
        end
    end

    // phase decision
    always_comb begin
        n_sel = lpg_pkg::SEL_ZERO;
        n_num = '0;
        n_den = '0;
        case (i_ctx.sel)
            lpg_pkg::SEL_BRIGHT: n_sel = lpg_pkg::SEL_BRIGHT;
            lpg_pkg::SEL_BLINK: begin
                n_sel = (i_pos < DW'(i_cfg.on_ms)) ? lpg_pkg::SEL_BRIGHT : lpg_pkg::SEL_ZERO;
            end
            lpg_pkg::SEL_SOS: begin
                n_sel = sos_lit ? lpg_pkg::SEL_BRIGHT : lpg_pkg::SEL_ZERO;
            end
            lpg_pkg::SEL_SEQ: begin
                n_sel = seq_lit ? lpg_pkg::SEL_BRIGHT : lpg_pkg::SEL_ZERO;
            end
            lpg_pkg::SEL_FADE: begin
                if (pos_f < s_in) begin
                    n_sel = lpg_pkg::SEL_QUOT;
                    n_num = pos_f[TW-1:0];
                    n_den = i_cfg.fade_in_ms;
                end else if (pos_f < s_hold) begin
                    n_sel = lpg_pkg::SEL_BRIGHT;
                end else if (pos_f < s_out) begin
                    n_sel = lpg_pkg::SEL_QUOT;
                    n_num = TW'(s_out - pos_f);
                    n_den = i_cfg.fade_out_ms;
                end
            end
            default: n_sel = lpg_pkg::SEL_ZERO;
        endcase
    end

    // decision and product stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
        r_ctx1     <= '{sel: n_sel, k: i_ctx.k, n: i_ctx.n};
        r_num1     <= n_num;
        r_den1     <= n_den;
        r_ctx2     <= r_ctx1;
        r_prod2    <= i_cfg.brightness * r_num1;
        r_den2     <= r_den1;
    end

    assign o_valid = r_vld2;
    assign o_num   = lpg_pkg::NUM_W'(r_prod2);
    assign o_den   = DW'(r_den2);
    assign o_ctx   = r_ctx2;

endmodule

@@ sv/led_pattern_level_generator.sv @@
// channel | signals                                  | transfer
// input   | i_start, o_busy, i_now_ms, i_elapsed_ms, | i_start high, o_busy low
//         | i_group_position, i_group_size           |
// result  | o_valid, o_level                         | o_valid high, one cycle
// config  | i_cfg_we, i_cfg_idx, i_cfg_data          | i_cfg_we high
//
// one item per cycle
// each result passes two 32-stage divider pipelines plus four registers
// synchronous reset clears valid bits and the configuration registers; o_busy stays low
// the receiver cannot stall, so the pipeline never holds
module led_pattern_level_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_elapsed_ms,
    input  logic [3:0]  i_group_position,
    input  logic [4:0]  i_group_size,
    output logic        o_valid,
    output logic [7:0]  o_level,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int DW = lpg_pkg::DEN_W;

    lpg_pkg::t_cfg r_cfg;

    logic                      r_vld0;
    logic [lpg_pkg::NUM_W-1:0] r_num0;
    logic [DW-1:0]             r_den0;
    lpg_pkg::t_ctx             r_ctx0;
    lpg_pkg::t_ctx             n_ctx0;
    logic [DW-1:0]             n_den0;
    logic [16:0]               blink_p;
    logic [17:0]               fade_p;
    logic [15:0]               sos_unit;

    logic                      d1_vld;
    logic [lpg_pkg::NUM_W-1:0] d1_quot;
    logic [DW-1:0]             d1_rem;
    lpg_pkg::t_ctx             d1_ctx;
    logic                      ph_vld;
    logic [lpg_pkg::NUM_W-1:0] ph_num;
    logic [DW-1:0]             ph_den;
    lpg_pkg::t_ctx             ph_ctx;
    logic                      d2_vld;
    logic [lpg_pkg::NUM_W-1:0] d2_quot;
    logic [DW-1:0]             d2_rem;
    lpg_pkg::t_ctx             d2_ctx;

    logic                      r_valid;
    logic [7:0]                r_level;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpg_pkg::REG_MODE:     r_cfg.mode        <= i_cfg_data[2:0];
                lpg_pkg::REG_BRIGHT:   r_cfg.brightness  <= i_cfg_data[7:0];
                lpg_pkg::REG_ON:       r_cfg.on_ms       <= i_cfg_data;
                lpg_pkg::REG_OFF:      r_cfg.off_ms      <= i_cfg_data;
                lpg_pkg::REG_FADE_IN:  r_cfg.fade_in_ms  <= i_cfg_data;
                lpg_pkg::REG_HOLD:     r_cfg.hold_ms     <= i_cfg_data;
                lpg_pkg::REG_FADE_OUT: r_cfg.fade_out_ms <= i_cfg_data;
                lpg_pkg::REG_GAP:      r_cfg.gap_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // period selection per mode
    always_comb begin
        blink_p  = {1'b0, r_cfg.on_ms} + {1'b0, r_cfg.off_ms};
        fade_p   = {2'b00, r_cfg.fade_in_ms} + {2'b00, r_cfg.hold_ms}
                 + {2'b00, r_cfg.fade_out_ms} + {2'b00, r_cfg.gap_ms};
        sos_unit = (r_cfg.on_ms == '0) ? 16'd1 : r_cfg.on_ms;
        n_ctx0.k   = i_group_position;
        n_ctx0.n   = i_group_size;
        n_ctx0.sel = lpg_pkg::SEL_ZERO;
        n_den0     = '0;
        unique case (r_cfg.mode)
            lpg_pkg::MODE_SOLID: n_ctx0.sel = lpg_pkg::SEL_BRIGHT;
            lpg_pkg::MODE_BLINK: begin
                n_ctx0.sel = (blink_p == '0) ? lpg_pkg::SEL_BRIGHT : lpg_pkg::SEL_BLINK;
                n_den0     = DW'(blink_p);
            end
            lpg_pkg::MODE_FADE: begin
                n_ctx0.sel = (fade_p == '0) ? lpg_pkg::SEL_BRIGHT : lpg_pkg::SEL_FADE;
                n_den0     = DW'(fade_p);
            end
            lpg_pkg::MODE_SOS: begin
                n_ctx0.sel = lpg_pkg::SEL_SOS;
                n_den0     = DW'(lpg_pkg::SOS_TOTAL) * DW'(sos_unit);
            end
            lpg_pkg::MODE_SEQ: begin
                if ((i_group_size == '0) || (r_cfg.on_ms == '0)) begin
                    n_ctx0.sel = lpg_pkg::SEL_ZERO;
                end else begin
                    n_ctx0.sel = lpg_pkg::SEL_SEQ;
                end
                n_den0 = DW'(i_group_size) * DW'(r_cfg.on_ms);
            end
            default: n_ctx0.sel = lpg_pkg::SEL_ZERO;
        endcase
    end

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= i_start;
        end
        r_num0 <= (r_cfg.mode == lpg_pkg::MODE_SEQ) ? i_now_ms : i_elapsed_ms;
        r_den0 <= n_den0;
        r_ctx0 <= n_ctx0;
    end

    // time modulo period
    lpg_div u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld0),
        .i_num   (r_num0),
        .i_den   (r_den0),
        .i_ctx   (r_ctx0),
        .o_valid (d1_vld),
        .o_quot  (d1_quot),
        .o_rem   (d1_rem),
        .o_ctx   (d1_ctx)
    );

    lpg_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (d1_vld),
        .i_pos   (d1_rem),
        .i_ctx   (d1_ctx),
        .o_valid (ph_vld),
        .o_num   (ph_num),
        .o_den   (ph_den),
        .o_ctx   (ph_ctx)
    );

    // fade ramp scaling
    lpg_div u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ph_vld),
        .i_num   (ph_num),
        .i_den   (ph_den),
        .i_ctx   (ph_ctx),
        .o_valid (d2_vld),
        .o_quot  (d2_quot),
        .o_rem   (d2_rem),
        .o_ctx   (d2_ctx)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d2_vld;
        end
        case (d2_ctx.sel)
            lpg_pkg::SEL_BRIGHT: r_level <= r_cfg.brightness;
            lpg_pkg::SEL_QUOT:   r_level <= (d2_quot[31:8] != '0 || d2_rem == '1)
                                            ? 8'hFF : d2_quot[7:0];
            default:             r_level <= '0;
        endcase
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_valid;
    assign o_level = r_level;

endmodule

@@ sv/lpg_checker.sv @@
module lpg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    localparam int LATENCY = 68;

    logic [6:0] r_warm;

    // cycles since reset, saturating at the latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != 7'(LATENCY)) begin
            r_warm <= r_warm + 7'd1;
        end
    end

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm == 7'(LATENCY)) |-> (o_valid == $past(i_start, LATENCY)))
        else $error("result strobe out of step with start");

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // no result can come out before the first transfer has crossed the pipeline
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm < 7'(LATENCY)) |-> !o_valid)
        else $error("result strobe during pipeline fill");

endmodule

bind led_pattern_level_generator lpg_checker u_lpg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);

@@ tb/tb_led_pattern_level_generator.sv @@
`timescale 1ns / 1ps

module tb_led_pattern_level_generator;

    localparam int LATENCY   = 68;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1800;

    // expected levels in issue order, with the predictor's own register copy
    class level_scoreboard;
        logic [2:0]  cfg_mode;
        logic [7:0]  cfg_bright;
        logic [15:0] cfg_on, cfg_off, cfg_fin, cfg_hold, cfg_fout, cfg_gap;
        logic [7:0]  pending_levels[$];
        int          errors;

        function new();
            cfg_mode = lpg_pkg::MODE_OFF;
            cfg_bright = '0;
            cfg_on = '0; cfg_off = '0; cfg_fin = '0;
            cfg_hold = '0; cfg_fout = '0; cfg_gap = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                lpg_pkg::REG_MODE:     cfg_mode = val[2:0];
                lpg_pkg::REG_BRIGHT:   cfg_bright = val[7:0];
                lpg_pkg::REG_ON:       cfg_on = val;
                lpg_pkg::REG_OFF:      cfg_off = val;
                lpg_pkg::REG_FADE_IN:  cfg_fin = val;
                lpg_pkg::REG_HOLD:     cfg_hold = val;
                lpg_pkg::REG_FADE_OUT: cfg_fout = val;
                lpg_pkg::REG_GAP:      cfg_gap = val;
                default: ;
            endcase
        endfunction

        // truncated ratio, capped at full scale
        function logic [7:0] ratio(logic [31:0] num, logic [31:0] den);
            logic [31:0] v;
            if (den == 0) return cfg_bright;
            v = (32'(cfg_bright) * num) / den;
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        function logic [7:0] pattern_level(logic [31:0] now, logic [31:0] t,
                                           logic [3:0] k, logic [4:0] n);
            logic [31:0] per, ph, unit, acc, start, stop;
            logic [7:0]  sos_units[18];
            logic        lit;
            sos_units = '{1, 1, 1, 1, 1, 3, 3, 1, 3, 1, 3, 3, 1, 1, 1, 1, 1, 7};
            case (cfg_mode)
                lpg_pkg::MODE_SOLID: return cfg_bright;
                lpg_pkg::MODE_BLINK: begin
                    per = 32'(cfg_on) + 32'(cfg_off);
                    if (per == 0) return cfg_bright;
                    return (t % per < cfg_on) ? cfg_bright : 8'd0;
                end
                lpg_pkg::MODE_FADE: begin
                    per = 32'(cfg_fin) + cfg_hold + cfg_fout + cfg_gap;
                    if (per == 0) return cfg_bright;
                    ph = t % per;
                    if (ph < cfg_fin) return ratio(ph, cfg_fin);
                    ph -= cfg_fin;
                    if (ph < cfg_hold) return cfg_bright;
                    ph -= cfg_hold;
                    if (ph < cfg_fout) return ratio(cfg_fout - ph, cfg_fout);
                    return 8'd0;
                end
                lpg_pkg::MODE_SOS: begin
                    unit = (cfg_on == 0) ? 32'd1 : 32'(cfg_on);
                    ph = t % (34 * unit);
                    acc = 0;
                    for (int i = 0; i < 18; i++) begin
                        acc += sos_units[i] * unit;
                        if (ph < acc) return (i % 2 == 0) ? cfg_bright : 8'd0;
                    end
                    return 8'd0;
                end
                lpg_pkg::MODE_SEQ: begin
                    if (n == 0 || cfg_on == 0) return 8'd0;
                    per = 32'(n) * cfg_on;
                    ph = now % per;
                    start = 32'(k) * cfg_on;
                    stop = start + cfg_on + cfg_off;
                    lit = (ph >= start) && (ph < stop);
                    if (!lit && stop > per) lit = ph < (stop - per);
                    return lit ? cfg_bright : 8'd0;
                end
                default: return 8'd0;
            endcase
        endfunction

        function void note_tick(logic [31:0] now, logic [31:0] t,
                                logic [3:0] k, logic [4:0] n);
            pending_levels.push_back(pattern_level(now, t, k, n));
        endfunction

        function void check_level(logic [7:0] got);
            logic [7:0] want;
            if (pending_levels.size() == 0) begin
                $error("unexpected level transfer: level=%0d", got);
                errors++;
                return;
            end
            want = pending_levels.pop_front();
            if (got !== want) begin
                $error("level mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [31:0] i_now_ms = '0;
    logic [31:0] i_elapsed_ms = '0;
    logic [3:0]  i_group_position = '0;
    logic [4:0]  i_group_size = '0;
    logic        o_valid;
    logic [7:0]  o_level;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    level_scoreboard sb = new();
    int idle_pct = 12;
    int wdog = 0;

    led_pattern_level_generator dut (.*);

    always #10 i_clk = ~i_clk;

    // result side: check every strobed level
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_level(o_level);
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || !i_rst_n) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("tb_led_pattern_level_generator: FAIL");
            $finish;
        end
    end

    // registers change only with the pipeline empty
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_start <= 1'b0;
        while (sb.pending_levels.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait out the pipeline before touching the registers
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending_levels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // one tick transfer, with random idle cycles in front
    task automatic send_tick(logic [31:0] now, logic [31:0] t,
                             logic [3:0] k, logic [4:0] n);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_now_ms <= now;
        i_elapsed_ms <= t;
        i_group_position <= k;
        i_group_size <= n;
        do @(posedge i_clk); while (o_busy);
        sb.note_tick(now, t, k, n);
    endtask

    // small times most of the time so patterns actually change phase
    function automatic logic [15:0] rand_ms();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(40));
        endcase
    endfunction

    task automatic random_config();
        write_reg(lpg_pkg::REG_MODE, 16'($urandom_range(7)));
        write_reg(lpg_pkg::REG_BRIGHT, ($urandom_range(3) == 0) ? 16'hFF : 16'($urandom));
        for (int r = lpg_pkg::REG_ON; r <= lpg_pkg::REG_GAP; r++) write_reg(3'(r), rand_ms());
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(300);
            default: return $urandom_range(3000);
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: mode off
        send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 5'd16);
        drain();

        // directed: each mode with extremes and special cases
        write_reg(lpg_pkg::REG_BRIGHT, 16'd255);
        write_reg(lpg_pkg::REG_MODE, 16'(lpg_pkg::MODE_SOLID));
        send_tick(32'd0, 32'd0, 4'd0, 5'd0);
        write_reg(lpg_pkg::REG_MODE, 16'(lpg_pkg::MODE_BLINK));
        send_tick(32'd0, 32'hFFFF_FFFF, 4'd0, 5'd0);   // zero period, steady
        write_reg(lpg_pkg::REG_ON, 16'd3);
        write_reg(lpg_pkg::REG_OFF, 16'd2);
        send_tick(32'd0, 32'd2, 4'd0, 5'd0);
        send_tick(32'd0, 32'd3, 4'd0, 5'd0);
        drain();
        write_reg(lpg_pkg::REG_MODE, 16'(lpg_pkg::MODE_FADE));
        send_tick(32'd0, 32'd7, 4'd0, 5'd0);           // all fade times zero
        write_reg(lpg_pkg::REG_FADE_IN, 16'hFFFF);
        write_reg(lpg_pkg::REG_HOLD, 16'd5);
        write_reg(lpg_pkg::REG_FADE_OUT, 16'd10);
        write_reg(lpg_pkg::REG_GAP, 16'hFFFF);
        send_tick(32'd0, 32'd1000, 4'd0, 5'd0);
        send_tick(32'd0, 32'd65537, 4'd0, 5'd0);
        send_tick(32'd0, 32'd65546, 4'd0, 5'd0);
        send_tick(32'd0, 32'd100000, 4'd0, 5'd0);
        drain();
        write_reg(lpg_pkg::REG_MODE, 16'(lpg_pkg::MODE_SOS));
        write_reg(lpg_pkg::REG_ON, 16'd0);            // zero unit counts as 1 ms
        for (int i = 0; i < 6; i++) send_tick(32'd0, 32'(i * 6 + 1), 4'd0, 5'd0);
        drain();
        write_reg(lpg_pkg::REG_MODE, 16'(lpg_pkg::MODE_SEQ));
        write_reg(lpg_pkg::REG_ON, 16'd10);
        write_reg(lpg_pkg::REG_OFF, 16'd15);
        send_tick(32'd5, 32'd0, 4'd0, 5'd0);               // empty group
        send_tick(32'hFFFF_FFFF, 32'd0, 4'd3, 5'd4);  // window wraps past end
        send_tick(32'd45, 32'd0, 4'd15, 5'd3);  // position beyond the group
        send_tick(32'd123, 32'd0, 4'd2, 5'd31); // oversized group
        drain();
        write_reg(lpg_pkg::REG_MODE, 16'd7);         // unused mode
        send_tick(32'd0, 32'd0, 4'd0, 5'd0);
        drain();

        // random phases with changing idle profiles
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) idle_pct = 71;
            if (i == 2 * N_RANDOM / 3) idle_pct = 0;
            if (i % 60 == 0) begin
                drain();
                random_config();
            end
            send_tick(rand_time(), rand_time(), 4'($urandom),
                      ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(16)));
        end

        drain();
        if (sb.errors == 0 && sb.pending_levels.size() == 0)
            $display("tb_led_pattern_level_generator: PASS");
        else
            $display("tb_led_pattern_level_generator: FAIL");
        $finish;
    end

endmodule
